// File: rtl/gn3_pkg.sv
package gn3_pkg;

    localparam int TABLE_SIZE_DEF     = 256;
    localparam int GRAD_FRAC_BITS_DEF = 14;

    // The point is scaled by 4096, so the low 12 bits of a Q19.12 coordinate are the fraction.
    localparam int COORD_W       = 32;
    localparam int CELL_BITS     = 12;
    localparam int CELL_W        = COORD_W - CELL_BITS;
    localparam int FRAC_ONE      = 4096;
    localparam int GRAD_W        = 16;
    localparam int DELTA_W       = CELL_BITS + 1;
    localparam int PROD_W        = GRAD_W + DELTA_W;
    localparam int VAL_W         = 32;
    localparam int FADE_W        = 17;
    localparam int FADE_SHIFT    = 16;
    localparam int LERP_W        = (VAL_W + 1) + (FADE_W + 1);
    localparam int NOISE_W       = 16;

    // Fade polynomial: w^3 * (6w^2 - 15*4096*w + 10*4096^2), Q0.60, rounded to Q1.16.
    localparam int   INNER_W     = 28;
    localparam int   INNER_HALF  = 14;
    localparam logic [29:0] FADE_C10 = 30'(10 * FRAC_ONE * FRAC_ONE);
    localparam logic [29:0] FADE_C15 = 30'(15 * FRAC_ONE);
    localparam logic [63:0] FADE_RND = 64'(1) << 43;
    localparam int   FADE_DROP   = 44;

    typedef enum logic [1:0] {
        OP_EVAL      = 2'd0,
        OP_LOAD_PERM = 2'd1,
        OP_LOAD_GRAD = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

endpackage

// File: rtl/gn3_front.sv
module gn3_front #(
    parameter int TABLE_SIZE = gn3_pkg::TABLE_SIZE_DEF,
    parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_operation,
    input  logic [7:0]                  s_table_index,
    input  logic [7:0]                  s_perm_value,
    input  logic signed [15:0]          s_grad_x,
    input  logic signed [15:0]          s_grad_y,
    input  logic signed [15:0]          s_grad_z,
    input  logic signed [31:0]          s_coord_x,
    input  logic signed [31:0]          s_coord_y,
    input  logic signed [31:0]          s_coord_z,
    input  logic                        q_full,
    output logic                        q_push,
    output gn3_pkg::op_t                f_op,
    output logic [IDX_W-1:0]            f_idx,
    output logic [IDX_W-1:0]            f_perm,
    output logic [IDX_W-1:0]            f_c0x,
    output logic [IDX_W-1:0]            f_c1x,
    output logic [IDX_W-1:0]            f_c0y,
    output logic [IDX_W-1:0]            f_c1y,
    output logic [IDX_W-1:0]            f_c0z,
    output logic [IDX_W-1:0]            f_c1z,
    output logic [11:0]                 f_fx,
    output logic [11:0]                 f_fy,
    output logic [11:0]                 f_fz
);
    import gn3_pkg::*;

    logic              in_range;
    logic              keep;
    logic signed [CELL_W-1:0] cell_x, cell_y, cell_z;

    assign f_op     = op_t'(s_operation);
    assign in_range = 32'(s_table_index) < TABLE_SIZE;

    // Unused codes and loads past the table end are consumed here and never queued.
    always_comb begin
        unique case (f_op)
            OP_EVAL:                    keep = 1'b1;
            OP_LOAD_PERM, OP_LOAD_GRAD: keep = in_range;
            default:                    keep = 1'b0;
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready && keep;

    assign f_idx  = IDX_W'(s_table_index);
    assign f_perm = IDX_W'(s_perm_value);

    // The table size is a power of two, so the low bits of the floor cell are its true modulo.
    assign cell_x = CELL_W'(s_coord_x >>> CELL_BITS);
    assign cell_y = CELL_W'(s_coord_y >>> CELL_BITS);
    assign cell_z = CELL_W'(s_coord_z >>> CELL_BITS);

    assign f_c0x = IDX_W'(cell_x);
    assign f_c0y = IDX_W'(cell_y);
    assign f_c0z = IDX_W'(cell_z);
    assign f_c1x = f_c0x + IDX_W'(1);
    assign f_c1y = f_c0y + IDX_W'(1);
    assign f_c1z = f_c0z + IDX_W'(1);

    assign f_fx = s_coord_x[CELL_BITS-1:0];
    assign f_fy = s_coord_y[CELL_BITS-1:0];
    assign f_fz = s_coord_z[CELL_BITS-1:0];

endmodule

// File: rtl/gn3_fifo.sv
module gn3_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/gn3_back.sv
module gn3_back #(
    parameter int TABLE_SIZE     = gn3_pkg::TABLE_SIZE_DEF,
    parameter int GRAD_FRAC_BITS = gn3_pkg::GRAD_FRAC_BITS_DEF,
    parameter int IDX_W          = $clog2(TABLE_SIZE)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  gn3_pkg::op_t         q_op,
    input  logic [IDX_W-1:0]     q_idx,
    input  logic [IDX_W-1:0]     q_perm,
    input  logic [15:0]          q_gx,
    input  logic [15:0]          q_gy,
    input  logic [15:0]          q_gz,
    input  logic [IDX_W-1:0]     q_c0x,
    input  logic [IDX_W-1:0]     q_c1x,
    input  logic [IDX_W-1:0]     q_c0y,
    input  logic [IDX_W-1:0]     q_c1y,
    input  logic [IDX_W-1:0]     q_c0z,
    input  logic [IDX_W-1:0]     q_c1z,
    input  logic [11:0]          q_fx,
    input  logic [11:0]          q_fy,
    input  logic [11:0]          q_fz,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_noise_value
);
    import gn3_pkg::*;

    localparam int OUT_F   = GRAD_FRAC_BITS + CELL_BITS;
    localparam int OUT_SH  = OUT_F - 15;
    localparam logic signed [33:0] OUT_RND = 34'sd1 <<< (OUT_F - 16);

    logic [IDX_W-1:0] perm1_mem [TABLE_SIZE];
    logic [IDX_W-1:0] perm2_mem [TABLE_SIZE];
    logic [IDX_W-1:0] perm3_mem [TABLE_SIZE];
    logic [47:0]      grad_mem  [TABLE_SIZE];

    logic en, hash_busy, is_eval, is_load, load_go, iss_valid;
    logic [2:0] corner_reg, corner_next;
    logic [IDX_W-1:0] iss_cx, iss_cy, iss_cz;
    logic [11:0] iss_f [3];

    // Hash and fade stages.
    logic              v1_reg, v2_reg, v3_reg, vg_reg;
    logic [2:0]        c1_reg, c2_reg, c3_reg, cg_reg;
    logic [IDX_W-1:0]  cy1_reg, cz1_reg, cz2_reg;
    logic [IDX_W-1:0]  h1_reg, h2_reg, h3_reg;
    logic [11:0]       fr1_reg [3];
    logic [11:0]       fr2_reg [3];
    logic [11:0]       fr3_reg [3];
    logic [11:0]       frg_reg [3];
    logic [23:0]       w2_reg [3];
    logic [35:0]       w3_reg [3];
    logic [INNER_W-1:0] inner_reg [3];
    logic [49:0]       plo_reg [3];
    logic [49:0]       phi_reg [3];
    logic [FADE_W-1:0] ug_reg [3];
    logic [47:0]       gword_reg;
    logic [29:0]       inner_full [3];
    logic [63:0]       fade_full [3];

    // Dot product stages.
    logic              vd1_reg, vd2_reg;
    logic [2:0]        cd1_reg, cd2_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [VAL_W-1:0]  vv_reg;
    logic [FADE_W-1:0] ud1_reg [3];
    logic [FADE_W-1:0] ud2_reg [3];
    logic signed [DELTA_W-1:0] dx, dy, dz;

    // Blend stages.
    logic signed [VAL_W-1:0]  ax_reg, ay_reg, az_reg;
    logic                     vx1_reg, vx2_reg, vy1_reg, vy2_reg, vz1_reg, vz2_reg;
    logic [1:0]               jx1_reg, jx2_reg;
    logic                     ky1_reg, ky2_reg;
    logic signed [LERP_W-1:0] prodx_reg, prody_reg, prodz_reg;
    logic signed [VAL_W-1:0]  ax1_reg, ay1_reg, az1_reg;
    logic signed [VAL_W-1:0]  xv_reg, yv_reg, n_reg;
    logic [FADE_W-1:0]        u1x1_reg, u2x1_reg, u1x2_reg, u2x2_reg, u2y1_reg, u2y2_reg;

    logic                     out_valid_reg;
    logic [NOISE_W-1:0]       out_noise_reg, out_noise_next;
    logic signed [33:0]       round_sum;
    logic signed [34:0]       round_val;

    // The whole corner pipeline advances together and freezes while a result waits.
    assign en        = !out_valid_reg || m_ready;
    assign hash_busy = v1_reg || v2_reg || v3_reg;

    always_comb begin
        is_eval = 1'b0;
        is_load = 1'b0;
        unique case (q_op)
            OP_EVAL:                    is_eval = q_valid;
            OP_LOAD_PERM, OP_LOAD_GRAD: is_load = q_valid;
            default: ;
        endcase
    end

    // A load waits until no earlier corner still has a table read ahead of it.
    assign load_go     = is_load && en && !hash_busy;
    assign iss_valid   = is_eval && en;
    assign q_pop       = (iss_valid && corner_reg == 3'd7) || load_go;
    assign corner_next = iss_valid ? corner_reg + 3'd1 : corner_reg;

    assign iss_cx   = corner_reg[0] ? q_c1x : q_c0x;
    assign iss_cy   = corner_reg[1] ? q_c1y : q_c0y;
    assign iss_cz   = corner_reg[2] ? q_c1z : q_c0z;
    assign iss_f[0] = q_fx;
    assign iss_f[1] = q_fy;
    assign iss_f[2] = q_fz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg <= 3'd0;
        end else begin
            corner_reg <= corner_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_go) begin
            if (q_op == OP_LOAD_PERM) begin
                perm1_mem[q_idx] <= q_perm;
                perm2_mem[q_idx] <= q_perm;
                perm3_mem[q_idx] <= q_perm;
            end else begin
                grad_mem[q_idx] <= {q_gx, q_gy, q_gz};
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            inner_full[a] = 30'(w2_reg[a]) * 30'(6) + FADE_C10 - 30'(fr1_reg[a]) * FADE_C15;
            fade_full[a]  = (64'(phi_reg[a]) << INNER_HALF) + 64'(plo_reg[a]) + FADE_RND;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h1_reg    <= perm1_mem[iss_cx];
            h2_reg    <= perm2_mem[h1_reg + cy1_reg];
            h3_reg    <= perm3_mem[h2_reg + cz2_reg];
            gword_reg <= grad_mem[h3_reg];

            c1_reg  <= corner_reg;
            cy1_reg <= iss_cy;
            cz1_reg <= iss_cz;
            c2_reg  <= c1_reg;
            cz2_reg <= cz1_reg;
            c3_reg  <= c2_reg;
            cg_reg  <= c3_reg;
            for (int a = 0; a < 3; a++) begin
                fr1_reg[a]   <= iss_f[a];
                w2_reg[a]    <= 24'(iss_f[a]) * 24'(iss_f[a]);
                fr2_reg[a]   <= fr1_reg[a];
                w3_reg[a]    <= 36'(w2_reg[a]) * 36'(fr1_reg[a]);
                inner_reg[a] <= inner_full[a][INNER_W-1:0];
                fr3_reg[a]   <= fr2_reg[a];
                plo_reg[a]   <= 50'(w3_reg[a]) * 50'(inner_reg[a][INNER_HALF-1:0]);
                phi_reg[a]   <= 50'(w3_reg[a]) * 50'(inner_reg[a][INNER_W-1:INNER_HALF]);
                frg_reg[a]   <= fr3_reg[a];
                ug_reg[a]    <= fade_full[a][FADE_DROP+FADE_W-1:FADE_DROP];
                ud1_reg[a]   <= ug_reg[a];
                ud2_reg[a]   <= ud1_reg[a];
            end
        end
    end

    // Offsets from the corner: the far corner of an axis sits one cell above.
    always_comb begin
        dx = $signed({1'b0, frg_reg[0]}) - (cg_reg[0] ? DELTA_W'(FRAC_ONE) : DELTA_W'(0));
        dy = $signed({1'b0, frg_reg[1]}) - (cg_reg[1] ? DELTA_W'(FRAC_ONE) : DELTA_W'(0));
        dz = $signed({1'b0, frg_reg[2]}) - (cg_reg[2] ? DELTA_W'(FRAC_ONE) : DELTA_W'(0));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cd1_reg <= cg_reg;
            px_reg  <= $signed(gword_reg[47:32]) * dx;
            py_reg  <= $signed(gword_reg[31:16]) * dy;
            pz_reg  <= $signed(gword_reg[15:0]) * dz;
            cd2_reg <= cd1_reg;
            vv_reg  <= VAL_W'(px_reg) + VAL_W'(py_reg) + VAL_W'(pz_reg);

            // Even corners are held as the low end of the x blend, odd ones complete it.
            if (vd2_reg && !cd2_reg[0]) begin
                ax_reg <= vv_reg;
            end
            jx1_reg   <= cd2_reg[2:1];
            ax1_reg   <= ax_reg;
            prodx_reg <= ((VAL_W + 1)'(vv_reg) - (VAL_W + 1)'(ax_reg)) *
                         $signed({1'b0, ud2_reg[0]});
            u1x1_reg  <= ud2_reg[1];
            u2x1_reg  <= ud2_reg[2];
            jx2_reg   <= jx1_reg;
            xv_reg    <= ax1_reg + VAL_W'(prodx_reg >>> FADE_SHIFT);
            u1x2_reg  <= u1x1_reg;
            u2x2_reg  <= u2x1_reg;

            if (vx2_reg && !jx2_reg[0]) begin
                ay_reg <= xv_reg;
            end
            ky1_reg   <= jx2_reg[1];
            ay1_reg   <= ay_reg;
            prody_reg <= ((VAL_W + 1)'(xv_reg) - (VAL_W + 1)'(ay_reg)) *
                         $signed({1'b0, u1x2_reg});
            u2y1_reg  <= u2x2_reg;
            ky2_reg   <= ky1_reg;
            yv_reg    <= ay1_reg + VAL_W'(prody_reg >>> FADE_SHIFT);
            u2y2_reg  <= u2y1_reg;

            if (vy2_reg && !ky2_reg) begin
                az_reg <= yv_reg;
            end
            az1_reg   <= az_reg;
            prodz_reg <= ((VAL_W + 1)'(yv_reg) - (VAL_W + 1)'(az_reg)) *
                         $signed({1'b0, u2y2_reg});
            n_reg     <= az1_reg + VAL_W'(prodz_reg >>> FADE_SHIFT);

            if (vz2_reg) begin
                out_noise_reg <= out_noise_next;
            end
        end
    end

    always_comb begin
        round_sum = 34'(n_reg) + OUT_RND;
        round_val = 35'(round_sum >>> OUT_SH) + 35'sd32768;
        if (round_val < 0) begin
            out_noise_next = '0;
        end else if (round_val > 35'sd65535) begin
            out_noise_next = '1;
        end else begin
            out_noise_next = round_val[NOISE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            vg_reg        <= 1'b0;
            vd1_reg       <= 1'b0;
            vd2_reg       <= 1'b0;
            vx1_reg       <= 1'b0;
            vx2_reg       <= 1'b0;
            vy1_reg       <= 1'b0;
            vy2_reg       <= 1'b0;
            vz1_reg       <= 1'b0;
            vz2_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= iss_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            vg_reg        <= v3_reg;
            vd1_reg       <= vg_reg;
            vd2_reg       <= vd1_reg;
            vx1_reg       <= vd2_reg && cd2_reg[0];
            vx2_reg       <= vx1_reg;
            vy1_reg       <= vx2_reg && jx2_reg[0];
            vy2_reg       <= vy1_reg;
            vz1_reg       <= vy2_reg && ky2_reg;
            vz2_reg       <= vz1_reg;
            out_valid_reg <= vz2_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_noise_value = out_noise_reg;

endmodule

// File: rtl/gradient_noise_3d.sv
// Evaluate: one corner enters the hash pipeline per cycle while the pipeline is not stalled;
// the eight corners of a point issue in turn, and a new point can start as soon as the last
// corner of the one before has gone in. Loads wait for pending hash reads to finish.
// The table size must be a power of two.
// Reset (synchronous, active low) empties the queue and the pipeline; table contents are
// kept and hold no defined value until loaded.
module gradient_noise_3d #(
    parameter int TABLE_SIZE     = gn3_pkg::TABLE_SIZE_DEF,
    parameter int GRAD_FRAC_BITS = gn3_pkg::GRAD_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [7:0]         s_table_index,
    input  logic [7:0]         s_perm_value,
    input  logic signed [15:0] s_grad_x,
    input  logic signed [15:0] s_grad_y,
    input  logic signed [15:0] s_grad_z,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_coord_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_noise_value
);
    import gn3_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int ENTRY_W = 2 + 8 * IDX_W + 48 + 36;

    logic q_full, q_push, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_din, q_dout;
    op_t  f_op, q_op;
    logic [1:0] q_op_bits;
    logic [IDX_W-1:0] f_idx, f_perm, f_c0x, f_c1x, f_c0y, f_c1y, f_c0z, f_c1z;
    logic [IDX_W-1:0] q_idx, q_perm, q_c0x, q_c1x, q_c0y, q_c1y, q_c0z, q_c1z;
    logic [11:0] f_fx, f_fy, f_fz, q_fx, q_fy, q_fz;
    logic [15:0] q_gx, q_gy, q_gz;

    gn3_front #(
        .TABLE_SIZE(TABLE_SIZE),
        .IDX_W     (IDX_W)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_table_index(s_table_index),
        .s_perm_value (s_perm_value),
        .s_grad_x     (s_grad_x),
        .s_grad_y     (s_grad_y),
        .s_grad_z     (s_grad_z),
        .s_coord_x    (s_coord_x),
        .s_coord_y    (s_coord_y),
        .s_coord_z    (s_coord_z),
        .q_full       (q_full),
        .q_push       (q_push),
        .f_op         (f_op),
        .f_idx        (f_idx),
        .f_perm       (f_perm),
        .f_c0x        (f_c0x),
        .f_c1x        (f_c1x),
        .f_c0y        (f_c0y),
        .f_c1y        (f_c1y),
        .f_c0z        (f_c0z),
        .f_c1z        (f_c1z),
        .f_fx         (f_fx),
        .f_fy         (f_fy),
        .f_fz         (f_fz)
    );

    assign q_din = {f_op, f_idx, f_perm, s_grad_x, s_grad_y, s_grad_z,
                    f_c0x, f_c1x, f_c0y, f_c1y, f_c0z, f_c1z, f_fx, f_fy, f_fz};

    gn3_fifo #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .din    (q_din),
        .full   (q_full),
        .pop    (q_pop),
        .valid  (q_valid),
        .dout   (q_dout)
    );

    assign {q_op_bits, q_idx, q_perm, q_gx, q_gy, q_gz,
            q_c0x, q_c1x, q_c0y, q_c1y, q_c0z, q_c1z, q_fx, q_fy, q_fz} = q_dout;
    assign q_op = op_t'(q_op_bits);

    gn3_back #(
        .TABLE_SIZE    (TABLE_SIZE),
        .GRAD_FRAC_BITS(GRAD_FRAC_BITS),
        .IDX_W         (IDX_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_op         (q_op),
        .q_idx        (q_idx),
        .q_perm       (q_perm),
        .q_gx         (q_gx),
        .q_gy         (q_gy),
        .q_gz         (q_gz),
        .q_c0x        (q_c0x),
        .q_c1x        (q_c1x),
        .q_c0y        (q_c0y),
        .q_c1y        (q_c1y),
        .q_c0z        (q_c0z),
        .q_c1z        (q_c1z),
        .q_fx         (q_fx),
        .q_fy         (q_fy),
        .q_fz         (q_fz),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_noise_value(m_noise_value)
    );

    a_pop_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_eval_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && f_op == OP_EVAL) |-> q_push)
        else $error("accepted evaluate transaction not queued");

    a_reset_quiet: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_valid)
        else $error("result valid right after reset");

endmodule
